### src/siphash_2_4_mac_core_assert.svh
// assertion macros for the siphash 2-4 mac core
// used by the control sequencer, no other dependencies
`ifndef SIPHASH_2_4_MAC_CORE_ASSERT_SVH
`define SIPHASH_2_4_MAC_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SH24_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define SH24_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sh24mac_pkg.sv
// shared types, constants and helpers for the siphash 2-4 mac core
// no dependencies
`default_nettype none

package sh24mac_pkg;

	// initialization constants of the scheme
	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

	// rounds per block and for finalization
	localparam int CRounds = 2;
	localparam int DRounds = 4;
	localparam int RndW = $clog2(DRounds);

	localparam logic [3:0] BYTES_PER_WORD = 4'd8;

	// configuration register indexes
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} lanes_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic do_round;
		logic absorb_end;
		logic add_len;
		logic start_fin;
		logic emit;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABS,
		ST_FIN,
		ST_OUT
	} st_t;

	// keep the low cnt bytes of a word, cnt below eight
	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < cnt) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### src/siphash_2_4_mac_core.sv
// siphash 2-4 mac: one round unit per cycle; a plain word is accepted, then runs two rounds
// last short item: accept, two absorb rounds, four finalization rounds, then the output write sets tag valid
// last full item: adds a length-only block before finalization; rate set by the round unit
// no new item while a word is in the rounds; the next item is taken while a tag waits
// reset clears control, key registers and message length; lanes load from the key
// at the first item of each message
`default_nettype none

module siphash_2_4_mac_core
	import sh24mac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [63:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        message_word,
	input  logic [3:0]         byte_count,
	input  logic               last_item,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        hash_value
);

	logic [63:0] key_low_q, key_high_q;
	lanes_t      lanes_q, base, rnd_out;
	logic [63:0] blk_q, first_blk, len_blk;
	logic [7:0]  len_q, len_base, len_new;
	logic        in_msg_q;
	logic [3:0]  cnt;
	logic        full;
	logic        accept;
	logic        out_valid_q;
	logic [63:0] hash_q;
	ctl_t        ctl;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign accept     = in_valid && in_ready;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// first block of an item and the updated length
	always_comb begin
		if (!last_item || byte_count > BYTES_PER_WORD) begin
			cnt = BYTES_PER_WORD;
		end else begin
			cnt = byte_count;
		end
		full     = (cnt == BYTES_PER_WORD);
		len_base = in_msg_q ? len_q : 8'd0;
		len_new  = len_base + {4'd0, cnt};
		if (full) begin
			first_blk = message_word;
		end else begin
			first_blk = (message_word & byte_mask(cnt)) | {len_new, 56'd0};
		end
		len_blk = {len_q, 56'd0};
	end

	// lanes start from the key at the first item of a message
	always_comb begin
		if (in_msg_q) begin
			base = lanes_q;
		end else begin
			base.v0 = key_low_q ^ SIP_C0;
			base.v1 = key_high_q ^ SIP_C1;
			base.v2 = key_low_q ^ SIP_C2;
			base.v3 = key_high_q ^ SIP_C3;
		end
	end

	sh24mac_round u_round (
		.a (lanes_q),
		.y (rnd_out)
	);

	sh24mac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item_last (last_item),
		.item_full (full),
		.out_valid (out_valid_q),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// lane and block registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_q.v0 <= base.v0;
			lanes_q.v1 <= base.v1;
			lanes_q.v2 <= base.v2;
			lanes_q.v3 <= base.v3 ^ first_blk;
			blk_q      <= first_blk;
		end else if (ctl.do_round) begin
			lanes_q.v0 <= ctl.absorb_end ? (rnd_out.v0 ^ blk_q) : rnd_out.v0;
			lanes_q.v1 <= rnd_out.v1;
			lanes_q.v2 <= ctl.start_fin ? (rnd_out.v2 ^ FIN_MARK) : rnd_out.v2;
			lanes_q.v3 <= ctl.add_len ? (rnd_out.v3 ^ len_blk) : rnd_out.v3;
			if (ctl.add_len) begin
				blk_q <= len_blk;
			end
		end
	end

	// message length and open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			in_msg_q <= 1'b0;
		end else if (accept) begin
			len_q    <= len_new;
			in_msg_q <= 1'b1;
		end else if (ctl.start_fin) begin
			len_q    <= '0;
			in_msg_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			hash_q <= lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;
		end
	end

endmodule

`default_nettype wire

### src/sh24mac_round.sv
// one siphash round over the four lanes, purely combinational
// depends on sh24mac_pkg for the lane struct
`default_nettype none

module sh24mac_round
	import sh24mac_pkg::*;
(
	input  lanes_t a,
	output lanes_t y
);

	logic [63:0] v0_a, v1_a, v2_a, v3_a;
	logic [63:0] v0_b, v2_b;

	// first half round
	always_comb begin
		v0_a = a.v0 + a.v1;
		v2_a = a.v2 + a.v3;
		v1_a = {a.v1[50:0], a.v1[63:51]} ^ v0_a;
		v3_a = {a.v3[47:0], a.v3[63:48]} ^ v2_a;
	end

	// second half round
	always_comb begin
		v2_b = v2_a + v1_a;
		v0_b = {v0_a[31:0], v0_a[63:32]} + v3_a;
		y.v0 = v0_b;
		y.v1 = {v1_a[46:0], v1_a[63:47]} ^ v2_b;
		y.v3 = {v3_a[42:0], v3_a[63:43]} ^ v0_b;
		y.v2 = {v2_b[31:0], v2_b[63:32]};
	end

endmodule

`default_nettype wire

### src/sh24mac_ctrl.sv
// sequencer that steps the shared round unit through absorb and finalization
// depends on sh24mac_pkg and the assertion macro header
`default_nettype none
`include "siphash_2_4_mac_core_assert.svh"

module sh24mac_ctrl
	import sh24mac_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic item_last,
	input  logic item_full,
	input  logic out_valid,
	input  logic out_ready,
	output ctl_t ctl
);

	localparam logic [RndW-1:0] RND_ABS_LAST = RndW'(CRounds - 1);
	localparam logic [RndW-1:0] RND_FIN_LAST = RndW'(DRounds - 1);

	st_t            st_q, st_d;
	logic [RndW-1:0] rnd_q, rnd_d;
	logic           extra_q, extra_d;
	logic           last_q, last_d;
	logic           accept;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			rnd_q   <= '0;
			extra_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			rnd_q   <= rnd_d;
			extra_q <= extra_d;
			last_q  <= last_d;
		end
	end

	// next state and commands
	always_comb begin
		st_d     = st_q;
		rnd_d    = rnd_q;
		extra_d  = extra_q;
		last_d   = last_q;
		in_ready = 1'b0;
		ctl      = '0;
		accept   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					st_d    = ST_ABS;
					rnd_d   = '0;
					last_d  = item_last;
					extra_d = item_last && item_full;
				end
			end
			ST_ABS: begin
				ctl.do_round = 1'b1;
				rnd_d = rnd_q + 1'b1;
				if (rnd_q == RND_ABS_LAST) begin
					ctl.absorb_end = 1'b1;
					rnd_d = '0;
					if (extra_q) begin
						// length-only block follows a full last word
						ctl.add_len = 1'b1;
						extra_d = 1'b0;
					end else if (last_q) begin
						ctl.start_fin = 1'b1;
						st_d = ST_FIN;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_FIN: begin
				ctl.do_round = 1'b1;
				rnd_d = rnd_q + 1'b1;
				if (rnd_q == RND_FIN_LAST) begin
					rnd_d = '0;
					st_d  = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid || out_ready) begin
					ctl.emit = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	`SH24_ASSERT_NEXT(a_full_last_extra, clk, arst_n, accept && item_last && item_full, extra_q, "full last word must queue a length block")
	`SH24_ASSERT_NEXT(a_fin_to_out, clk, arst_n, (st_q == ST_FIN) && (rnd_q == RND_FIN_LAST), st_q == ST_OUT, "finalization must end after four rounds")
	`SH24_ASSERT_NEXT(a_word_done, clk, arst_n, (st_q == ST_ABS) && (rnd_q == RND_ABS_LAST) && !extra_q && !last_q, in_ready, "plain word must return to idle after two rounds")
	`SH24_ASSERT_NOW(a_emit_free, clk, arst_n, ctl.emit, !out_valid || out_ready, "tag written over a pending transaction")

endmodule

`default_nettype wire

### tb/sv/siphash_2_4_mac_core_test.sv
// self-checking testbench for the siphash 2-4 mac core: directed vectors, then random messages
// checked against an in-bench tag predictor; depends on sh24mac_pkg and siphash_2_4_mac_core
`timescale 1ns / 100ps

module siphash_2_4_mac_core_test;
	import sh24mac_pkg::*;

	// one directed stimulus row, known_tag used only when tag_known is set
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
		logic        tag_known;
		logic [63:0] known_tag;
	} stim_row_t;

	localparam int NumDirected = 20;
	localparam int NumPhases = 6;
	localparam int RandomItems = 1930;
	localparam logic [63:0] ONES = 64'hffffffffffffffff;
	localparam logic [63:0] VEC_KEY_LOW = 64'h0706050403020100;
	localparam logic [63:0] VEC_KEY_HIGH = 64'h0f0e0d0c0b0a0908;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = CFG_KEY_LOW;
	logic [63:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [63:0]        message_word = '0;
	logic [3:0]         byte_count = '0;
	logic               last_item = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [63:0]        hash_value;

	// predictor state: key copy, lanes, running length, open message flag
	logic [63:0] key_lo = '0;
	logic [63:0] key_hi = '0;
	lanes_t      mac_lanes = '0;
	logic [7:0]  mac_len = '0;
	logic        mac_open = 1'b0;

	logic [63:0] pending_tags[$];
	logic [63:0] oldest_tag;
	int          failures = 0;
	int          items_sent = 0;
	logic        sender_calm = 1'b0;
	logic        flood_on = 1'b0;
	logic        flood_done = 1'b0;

	// directed rows under the 00..0f key; first three messages are published vectors
	stim_row_t directed_rows [NumDirected] = '{
		'{64'h0000000000000000, 4'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31},
		'{64'hffffffffffffff00, 4'd1, 1'b1, 1'b1, 64'h74f839c593dc67fd},
		'{64'h0706050403020100, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hff0e0d0c0b0a0908, 4'd7, 1'b1, 1'b1, 64'ha129ca6149be45e5},
		'{ONES,                 4'd8, 1'b1, 1'b0, 64'h0},
		'{64'h0000000000000000, 4'd8, 1'b1, 1'b0, 64'h0},
		'{64'haaaaaaaaaaaaaaaa, 4'd3, 1'b0, 1'b0, 64'h0},
		'{64'h5555555555555555, 4'd9, 1'b1, 1'b0, 64'h0},
		'{ONES,                 4'd15, 1'b1, 1'b0, 64'h0},
		'{ONES,                 4'd0, 1'b0, 1'b0, 64'h0},
		'{ONES,                 4'd7, 1'b1, 1'b0, 64'h0},
		'{64'h0123456789abcdef, 4'd4, 1'b1, 1'b0, 64'h0},
		'{64'hfedcba9876543210, 4'd15, 1'b0, 1'b0, 64'h0},
		'{64'h8000000000000001, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hdeadbeefcafef00d, 4'd2, 1'b1, 1'b0, 64'h0},
		'{64'h0000000000000000, 4'd12, 1'b1, 1'b0, 64'h0},
		'{64'h8000000000000000, 4'd5, 1'b1, 1'b0, 64'h0},
		'{64'h00ff00ff00ff00ff, 4'd6, 1'b1, 1'b0, 64'h0},
		'{64'hff00ff00ff00ff00, 4'd3, 1'b1, 1'b0, 64'h0},
		'{64'h00000000000000ff, 4'd1, 1'b1, 1'b0, 64'h0}
	};

	siphash_2_4_mac_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// one sipround on all four lanes
	function automatic lanes_t sip_mix(input lanes_t s);
		s.v0 = s.v0 + s.v1;
		s.v2 = s.v2 + s.v3;
		s.v1 = rotl64(s.v1, 13) ^ s.v0;
		s.v3 = rotl64(s.v3, 16) ^ s.v2;
		s.v0 = rotl64(s.v0, 32);
		s.v2 = s.v2 + s.v1;
		s.v0 = s.v0 + s.v3;
		s.v1 = rotl64(s.v1, 17) ^ s.v2;
		s.v3 = rotl64(s.v3, 21) ^ s.v0;
		s.v2 = rotl64(s.v2, 32);
		return s;
	endfunction

	// block absorption with two rounds
	function automatic lanes_t sip_absorb(input lanes_t s, input logic [63:0] m);
		s.v3 = s.v3 ^ m;
		s = sip_mix(sip_mix(s));
		s.v0 = s.v0 ^ m;
		return s;
	endfunction

	// advance the tag predictor by one accepted item
	task automatic siphash_update(input logic [63:0] word, input logic [3:0] cnt,
			input logic last, output logic tag_ready, output logic [63:0] tag);
		logic [63:0] tail;
		int          n;
		tail = '0;
		n = (cnt > 4'd8) ? 8 : int'(cnt);
		tag_ready = 1'b0;
		tag = '0;
		// key is sampled only by the first item of a message
		if (!mac_open) begin
			mac_lanes.v0 = key_lo ^ SIP_C0;
			mac_lanes.v1 = key_hi ^ SIP_C1;
			mac_lanes.v2 = key_lo ^ SIP_C2;
			mac_lanes.v3 = key_hi ^ SIP_C3;
			mac_len = '0;
			mac_open = 1'b1;
		end
		if (!last || n == 8) begin
			mac_lanes = sip_absorb(mac_lanes, word);
			mac_len = mac_len + 8'd8;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (i < n) tail[i*8 +: 8] = word[i*8 +: 8];
			end
			mac_len = mac_len + 8'(n);
		end
		if (last) begin
			// final block carries the length byte, then finalization
			mac_lanes = sip_absorb(mac_lanes, tail | {mac_len, 56'h0});
			mac_lanes.v2 = mac_lanes.v2 ^ FIN_MARK;
			for (int r = 0; r < DRounds; r++) mac_lanes = sip_mix(mac_lanes);
			tag = mac_lanes.v0 ^ mac_lanes.v1 ^ mac_lanes.v2 ^ mac_lanes.v3;
			tag_ready = 1'b1;
			mac_open = 1'b0;
			mac_len = '0;
		end
	endtask

	// present one item and hold it until the transaction completes
	task automatic offer_item(input logic [63:0] word, input logic [3:0] cnt, input logic last,
			input logic tag_known, input logic [63:0] known_tag);
		logic        tag_ready;
		logic [63:0] tag;
		@(negedge clk);
		message_word <= word;
		byte_count <= cnt;
		last_item <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		siphash_update(word, cnt, last, tag_ready, tag);
		if (tag_ready) pending_tags.push_back(tag_known ? known_tag : tag);
		items_sent++;
	endtask

	// random sender gap, about a quarter of the time unless calm
	task automatic idle_gap();
		int n;
		n = 0;
		if (!sender_calm && $urandom_range(0, 99) < 25) n = $urandom_range(1, 4);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop offering and let every tag drain, then cover the block's tail latency
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_KEY_LOW) key_lo = value;
		else key_hi = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one random message: mostly short, a few long enough to wrap the length byte
	task automatic send_message();
		int          words;
		logic [3:0]  cnt;
		words = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 40) : $urandom_range(0, 4);
		for (int w = 0; w < words; w++) begin
			cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : BYTES_PER_WORD;
			offer_item(random_word(), cnt, 1'b0, 1'b0, '0);
			idle_gap();
		end
		cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		offer_item(random_word(), cnt, 1'b1, 1'b0, '0);
		idle_gap();
	endtask

	// result check against the oldest predicted tag
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tags.size() == 0) begin
				$error("unexpected result: hash_value %h", hash_value);
				failures++;
			end else begin
				oldest_tag = pending_tags.pop_front();
				if (hash_value !== oldest_tag) begin
					$error("hash_value mismatch: expected %h, actual %h", oldest_tag, hash_value);
					failures++;
				end
			end
		end
	end

	// result side: random stalls, calm windows, one long hold-off during the flood
	initial begin : result_sink
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (flood_on && !flood_done) begin
				out_ready <= 1'b0;
				for (int hold = 1; hold < 400; hold++) @(negedge clk);
				flood_done = 1'b1;
			end else if ((cyc / 800) % 4 == 2) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 25);
			end
			cyc++;
		end
	end

	// run limit
	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

	// reset, directed table, then random phases with key changes between them
	initial begin : stimulus
		int budget;
		int wait_cycles;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		write_key(CFG_KEY_LOW, VEC_KEY_LOW);
		write_key(CFG_KEY_HIGH, VEC_KEY_HIGH);
		for (int i = 0; i < NumDirected; i++) begin
			offer_item(directed_rows[i].word, directed_rows[i].count, directed_rows[i].last,
				directed_rows[i].tag_known, directed_rows[i].known_tag);
			idle_gap();
		end

		items_sent = 0;
		for (int p = 0; p < NumPhases; p++) begin
			// leave a message open across the last key change
			if (p == NumPhases - 1) begin
				offer_item(random_word(), BYTES_PER_WORD, 1'b0, 1'b0, '0);
				offer_item(random_word(), 4'd3, 1'b0, 1'b0, '0);
			end
			drain_block();
			case (p)
				0: begin
					write_key(CFG_KEY_LOW, '0);
					write_key(CFG_KEY_HIGH, '0);
				end
				1: begin
					write_key(CFG_KEY_HIGH, ONES);
					write_key(CFG_KEY_LOW, ONES);
				end
				default: begin
					write_key(CFG_KEY_LOW, {$urandom, $urandom});
					write_key(CFG_KEY_HIGH, {$urandom, $urandom});
				end
			endcase
			if (p == NumPhases - 1) offer_item(random_word(), 4'd5, 1'b1, 1'b0, '0);
			sender_calm = (p == 3);

			// back-to-back one-item messages while results are held off
			if (p == 4) begin
				flood_on = 1'b1;
				for (int k = 0; k < 40; k++) offer_item(random_word(), 4'($urandom_range(0, 8)),
					1'b1, 1'b0, '0);
				flood_on = 1'b0;
			end

			budget = RandomItems * (p + 1) / NumPhases;
			while (items_sent < budget) send_message();
		end

		// final drain with a bound
		@(negedge clk);
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_tags.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_tags.size() != 0) begin
			$error("%0d expected hash_value results never arrived", pending_tags.size());
			failures++;
		end
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/sh24mac_pkg.sv
src/sh24mac_round.sv
src/sh24mac_ctrl.sv
src/siphash_2_4_mac_core.sv
tb/sv/siphash_2_4_mac_core_test.sv
